FILE: src/dsf3_pkg.sv
`timescale 1ns / 1ps
package dsf3_pkg;

    // Register indexes of the configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd1;
    localparam int CFG_DATA_W = 31;

    // Gain numerator: (35 * 2^7)^2 * 2^16, damping in Q9.7
    localparam logic [63:0] GAIN_NUM = 64'd1315333734400;
    localparam logic [15:0] RESET_DAMPING = 16'd51;
    localparam logic [30:0] RESET_MAX_SPEED = 31'd655360;

    // Division by 60: split at bit 31, since 2^31 = 60 * 35791394 + 8.
    // The low part (below 2^32) uses the reciprocal ceil(2^38 / 60).
    localparam logic [32:0] DIV60_MUL = 33'd4581298450;
    localparam logic [25:0] DIV60_HI  = 26'd35791394;
    // Dividends at or above 60 * 2^32 always saturate the sum, so cap them there
    localparam logic [37:0] DIV60_CAP = 38'd257698037760;

    typedef logic signed [31:0] t_q16;

    // Saturate a wide signed value to 32 bits
    function automatic t_q16 sat32(input logic signed [63:0] x);
        t_q16 r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // One restoring division step: returns {remainder, shifted quotient}
    function automatic logic [95:0] div_step(input logic [31:0] rem,
                                             input logic [63:0] quo,
                                             input logic [31:0] den);
        logic [32:0] t;
        logic [63:0] q;
        logic [31:0] r;
        t = {rem, quo[63]};
        q = {quo[62:0], 1'b0};
        if (t >= {1'b0, den}) begin
            r = 32'(t - {1'b0, den});
            q[0] = 1'b1;
        end else begin
            r = t[31:0];
        end
        return {r, q};
    endfunction

endpackage

FILE: src/damped_spring_follower_3d.sv
`timescale 1ns / 1ps
// Each input transaction runs one sequenced pass, longer when the speed clamp applies.
// The input stalls for the whole pass, so a new transaction is taken only after the last
// result is loaded; the shared radix-4 divider (gain, and each axis for the clamp) and the
// square root set the pace. A stalled output holds the sequencer in its last state.
// Reset (synchronous, active low) clears velocity, loads damping 51 and max speed
// 655360 (10.0), and empties the output register.
module damped_spring_follower_3d (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [31:0]                     i_now_x,
    input  logic signed [31:0]                     i_now_y,
    input  logic signed [31:0]                     i_now_z,
    input  logic signed [31:0]                     i_goal_x,
    input  logic signed [31:0]                     i_goal_y,
    input  logic signed [31:0]                     i_goal_z,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [31:0]                     o_next_x,
    output logic signed [31:0]                     o_next_y,
    output logic signed [31:0]                     o_next_z,
    output logic                                   o_snapped,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [dsf3_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [dsf3_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import dsf3_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DSQ  = 5'd1;
    localparam logic [4:0] S_GDIV = 5'd2;
    localparam logic [4:0] S_GW   = 5'd3;
    localparam logic [4:0] S_M1   = 5'd4;
    localparam logic [4:0] S_M2   = 5'd5;
    localparam logic [4:0] S_M3   = 5'd6;
    localparam logic [4:0] S_AW   = 5'd7;
    localparam logic [4:0] S_SQ   = 5'd8;
    localparam logic [4:0] S_SQA  = 5'd9;
    localparam logic [4:0] S_MS   = 5'd10;
    localparam logic [4:0] S_CMP  = 5'd11;
    localparam logic [4:0] S_SQRT = 5'd12;
    localparam logic [4:0] S_CM   = 5'd13;
    localparam logic [4:0] S_CD   = 5'd14;
    localparam logic [4:0] S_CW   = 5'd15;
    localparam logic [4:0] S_POS  = 5'd16;
    localparam logic [4:0] S_PW   = 5'd17;
    localparam logic [4:0] S_DOT  = 5'd18;
    localparam logic [4:0] S_DA   = 5'd19;
    localparam logic [4:0] S_FIN  = 5'd20;
    localparam logic [4:0] S_AM   = 5'd21;
    localparam logic [4:0] S_PM   = 5'd22;

    logic [4:0]  r_state, n_state;
    logic [1:0]  r_ax;
    logic [15:0] r_damp;
    logic [30:0] r_ms;
    t_q16        r_vel [3];
    t_q16        r_now [3];
    t_q16        r_goal [3];
    t_q16        r_nxt [3];
    logic [40:0] r_gain;
    logic [63:0] r_m;
    logic [63:0] r_len2;
    logic [31:0] r_len;
    logic signed [69:0] r_dot;
    logic        r_aneg;
    logic [37:0] r_y;
    logic signed [67:0] r_prod;
    logic        r_oval;
    t_q16        r_ox, r_oy, r_oz;
    logic        r_osnap;

    // Divider and square root unit registers
    logic [31:0] r_drem;
    logic [63:0] r_dq;
    logic [31:0] r_dden;
    logic [4:0]  r_dcnt;
    logic        r_dbusy;
    logic [63:0] r_sx;
    logic [63:0] r_sr;
    logic [63:0] r_sbit;
    logic        r_sbusy;

    logic        in_acc, out_acc, fin_go;
    logic signed [33:0] mul_a, mul_b;
    logic [15:0] d_eff;
    logic signed [32:0] span, gmn;
    logic [32:0] absd, absv;
    logic signed [63:0] v64, m_tot, spring, acc, absacc, qs;
    logic [37:0] yclamp;
    logic [31:0] t60;
    logic [32:0] hi60, q60;
    logic [95:0] ds1, ds2;
    logic [63:0] s_t;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = r_oval && !i_out_stall;
    assign fin_go      = (r_state == S_FIN) && !(r_oval && i_out_stall);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_oval;
    assign o_next_x    = r_ox;
    assign o_next_y    = r_oy;
    assign o_next_z    = r_oz;
    assign o_snapped   = r_osnap;

    // Per-axis operands
    always_comb begin
        d_eff  = (r_damp == 16'd0) ? 16'd1 : r_damp;
        span   = {r_goal[r_ax][31], r_goal[r_ax]} - {r_now[r_ax][31], r_now[r_ax]};
        absd   = span[32] ? 33'(-span) : 33'(span);
        v64    = 64'(r_vel[r_ax]);
        absv   = r_vel[r_ax][31] ? 33'(-(33'(r_vel[r_ax]))) : 33'(r_vel[r_ax]);
        gmn    = {r_goal[r_ax][31], r_goal[r_ax]} - {r_nxt[r_ax][31], r_nxt[r_ax]};
        m_tot  = signed'(r_m + {31'd0, r_prod[48:16]});
        spring = span[32] ? -m_tot : m_tot;
        acc    = spring - ((v64 <<< 5) + (v64 <<< 1) + v64);
        absacc = acc[63] ? -acc : acc;
        yclamp = ($unsigned(absacc) >= 64'(DIV60_CAP)) ? DIV60_CAP : absacc[37:0];
        t60    = 32'({r_y[37:31], 3'b000}) + 32'(r_y[30:0]);
        hi60   = 33'(r_y[37:31]) * 33'(DIV60_HI);
        q60    = hi60 + 33'(r_prod[64:38]);
        qs     = r_aneg ? -signed'(64'(q60)) : signed'(64'(q60));
        ds1    = div_step(r_drem, r_dq, r_dden);
        ds2    = div_step(ds1[95:64], ds1[63:0], r_dden);
        s_t    = r_sr + r_sbit;
    end

    // Select shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state) inside
            S_DSQ: begin
                mul_a = {18'd0, d_eff};
                mul_b = {18'd0, d_eff};
            end
            S_M1: begin
                mul_a = {9'd0, r_gain[40:16]};
                mul_b = {1'b0, absd};
            end
            S_M2: begin
                mul_a = {18'd0, r_gain[15:0]};
                mul_b = {1'b0, absd};
            end
            S_AM, S_PM: begin
                mul_a = {2'b00, t60};
                mul_b = {1'b0, DIV60_MUL};
            end
            S_SQ: begin
                mul_a = 34'(r_vel[r_ax]);
                mul_b = 34'(r_vel[r_ax]);
            end
            S_MS: begin
                mul_a = {3'd0, r_ms};
                mul_b = {3'd0, r_ms};
            end
            S_CM: begin
                mul_a = {1'b0, absv};
                mul_b = {3'd0, r_ms};
            end
            S_DOT: begin
                mul_a = 34'(gmn);
                mul_b = 34'(span);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_DSQ;
            S_DSQ:  n_state = S_GDIV;
            S_GDIV: n_state = S_GW;
            S_GW:   if (!r_dbusy) n_state = S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_AM;
            S_AM:   n_state = S_AW;
            S_AW:   n_state = S_SQ;
            S_SQ:   n_state = S_SQA;
            S_SQA:  n_state = (r_ax == 2'd2) ? S_MS : S_M1;
            S_MS:   n_state = S_CMP;
            S_CMP:  n_state = (r_len2 > r_prod[63:0]) ? S_SQRT : S_POS;
            S_SQRT: if (!r_sbusy) n_state = S_CM;
            S_CM:   n_state = S_CD;
            S_CD:   n_state = S_CW;
            S_CW:   if (!r_dbusy) n_state = (r_ax == 2'd2) ? S_POS : S_CM;
            S_POS:  n_state = S_PM;
            S_PM:   n_state = S_PW;
            S_PW:   n_state = S_DOT;
            S_DOT:  n_state = S_DA;
            S_DA:   n_state = (r_ax == 2'd2) ? S_FIN : S_POS;
            S_FIN:  if (fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control, velocity and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_damp  <= RESET_DAMPING;
            r_ms    <= RESET_MAX_SPEED;
            r_oval  <= 1'b0;
            r_dbusy <= 1'b0;
            r_sbusy <= 1'b0;
            r_ax    <= 2'd0;
            for (int i = 0; i < 3; i++) r_vel[i] <= '0;
        end else begin
            r_state <= n_state;

            // Take configuration writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_DAMPING:   r_damp <= i_cfg_data[15:0];
                    CFG_MAX_SPEED: r_ms   <= i_cfg_data[30:0];
                    default: ;
                endcase
            end

            // Drop the result once taken, load a new one at the end of a pass
            if (fin_go) r_oval <= 1'b1;
            else if (out_acc) r_oval <= 1'b0;

            // Advance the divider, two quotient bits a cycle
            if ((r_state == S_GDIV) || (r_state == S_CD)) begin
                r_dbusy <= 1'b1;
            end else if (r_dbusy && (r_dcnt == 5'd31)) begin
                r_dbusy <= 1'b0;
            end

            // Advance the square root, one result bit a cycle
            if ((r_state == S_CMP) && (r_len2 > r_prod[63:0])) begin
                r_sbusy <= 1'b1;
            end else if (r_sbusy && (r_sbit == 64'd1)) begin
                r_sbusy <= 1'b0;
            end

            // Axis counter
            unique case (r_state) inside
                S_IDLE: r_ax <= 2'd0;
                S_SQA, S_DA: r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                S_CW: if (!r_dbusy) r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                default: ;
            endcase

            // Velocity updates
            if (r_state == S_AW) begin
                r_vel[r_ax] <= sat32(v64 + qs);
            end
            if ((r_state == S_CW) && !r_dbusy) begin
                r_vel[r_ax] <= r_aneg ? -signed'(r_dq[31:0]) : signed'(r_dq[31:0]);
            end
            if (fin_go && r_dot[69]) begin
                for (int i = 0; i < 3; i++) r_vel[i] <= '0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        // Capture the item
        if (in_acc) begin
            r_now[0]  <= i_now_x;
            r_now[1]  <= i_now_y;
            r_now[2]  <= i_now_z;
            r_goal[0] <= i_goal_x;
            r_goal[1] <= i_goal_y;
            r_goal[2] <= i_goal_z;
            r_len2    <= '0;
            r_dot     <= '0;
        end

        // Start the divider, or load a dividend for the divide by 60
        unique case (r_state)
            S_GDIV: begin
                r_drem <= '0;
                r_dq   <= GAIN_NUM;
                r_dden <= r_prod[31:0];
                r_dcnt <= '0;
            end
            S_M3: begin
                r_y    <= yclamp;
                r_aneg <= acc[63];
            end
            S_CD: begin
                r_drem <= '0;
                r_dq   <= r_prod[63:0];
                r_dden <= r_len;
                r_dcnt <= '0;
                r_aneg <= r_vel[r_ax][31];
            end
            S_POS: begin
                r_y    <= {5'd0, absv};
                r_aneg <= r_vel[r_ax][31];
            end
            default: begin
                if (r_dbusy) begin
                    r_drem <= ds2[95:64];
                    r_dq   <= ds2[63:0];
                    r_dcnt <= r_dcnt + 5'd1;
                end
            end
        endcase

        // Gain and spring partial sums
        if ((r_state == S_GW) && !r_dbusy) r_gain <= r_dq[40:0];
        if (r_state == S_M2) r_m <= {6'd0, r_prod[57:0]};

        // Speed squared, clamp length
        if (r_state == S_SQA) r_len2 <= r_len2 + r_prod[63:0];
        if ((r_state == S_SQRT) && !r_sbusy) r_len <= r_sr[31:0];

        // Square root unit
        if ((r_state == S_CMP) && (r_len2 > r_prod[63:0])) begin
            r_sx   <= r_len2;
            r_sr   <= '0;
            r_sbit <= 64'd1 << 62;
        end else if (r_sbusy) begin
            if (r_sx >= s_t) begin
                r_sx <= r_sx - s_t;
                r_sr <= (r_sr >> 1) + r_sbit;
            end else begin
                r_sr <= r_sr >> 1;
            end
            r_sbit <= r_sbit >> 2;
        end

        // New position and overshoot dot product
        if (r_state == S_PW) begin
            r_nxt[r_ax] <= sat32(64'(r_now[r_ax]) + qs);
        end
        if (r_state == S_DA) r_dot <= r_dot + 70'(r_prod);

        // Hold the result for the output transaction
        if (fin_go) begin
            r_osnap <= r_dot[69];
            r_ox    <= r_dot[69] ? r_goal[0] : r_nxt[0];
            r_oy    <= r_dot[69] ? r_goal[1] : r_nxt[1];
            r_oz    <= r_dot[69] ? r_goal[2] : r_nxt[2];
        end
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import dsf3_pkg::*;

    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic               snap;
    } t_follow;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [31:0] i_now_x = '0, i_now_y = '0, i_now_z = '0;
    logic signed [31:0] i_goal_x = '0, i_goal_y = '0, i_goal_z = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [31:0] o_next_x, o_next_y, o_next_z;
    logic o_snapped;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    damped_spring_follower_3d u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Follower model state
    logic [15:0] damp_q;
    logic [30:0] vmax_q;
    logic signed [63:0] vel_q [3];
    t_follow pending_pos [$];

    int mismatches = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;       // no idling in the last part
    bit hold_rx = 1'b0;    // long receiver hold-off

    localparam int WATCHDOG = 20000;

    function automatic logic signed [63:0] clip32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Advance the model by one transaction and return the expected position
    function automatic t_follow follow_step(input logic signed [31:0] nw [3],
                                            input logic signed [31:0] gl [3]);
        logic [63:0] d, gain, gh, gl16, len2, len, m, mag;
        logic signed [63:0] span [3], nxt [3], spring, acc;
        logic signed [127:0] dot;
        t_follow r;
        d = (damp_q == 0) ? 64'd1 : 64'(damp_q);
        gain = GAIN_NUM / (d * d);
        gh = gain >> 16;
        gl16 = gain & 64'hFFFF;
        len2 = 0;
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            span[i] = 64'(gl[i]) - 64'(nw[i]);
            mag = span[i] < 0 ? 64'(-span[i]) : 64'(span[i]);
            m = gh * mag + ((gl16 * mag) >> 16);
            spring = span[i] < 0 ? -$signed(m) : $signed(m);
            acc = spring - 64'sd35 * vel_q[i];
            vel_q[i] = clip32(vel_q[i] + acc / 64'sd60);
            len2 += 64'(vel_q[i] * vel_q[i]);
        end
        if (len2 > 64'(vmax_q) * 64'(vmax_q)) begin
            len = root64(len2);
            for (int i = 0; i < 3; i++)
                vel_q[i] = (vel_q[i] * $signed(64'(vmax_q))) / $signed(len);
        end
        for (int i = 0; i < 3; i++) begin
            nxt[i] = clip32(64'(nw[i]) + vel_q[i] / 64'sd60);
            dot += 128'(64'(gl[i]) - nxt[i]) * 128'(span[i]);
        end
        r.snap = dot < 0;
        if (r.snap) begin
            for (int i = 0; i < 3; i++) begin
                nxt[i] = 64'(gl[i]);
                vel_q[i] = 0;
            end
        end
        r.nx = nxt[0][31:0];
        r.ny = nxt[1][31:0];
        r.nz = nxt[2][31:0];
        return r;
    endfunction

    task automatic idle_burst();
        if (!calm && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
    endtask

    // Send one transaction and predict its result
    task automatic send_pos(input logic signed [31:0] nx, ny, nz, gx, gy, gz);
        logic signed [31:0] nw [3], gg [3];
        nw = '{nx, ny, nz};
        gg = '{gx, gy, gz};
        i_in_valid <= 1'b1;
        {i_now_x, i_now_y, i_now_z} <= {nx, ny, nz};
        {i_goal_x, i_goal_y, i_goal_z} <= {gx, gy, gz};
        do @(posedge i_clk); while (o_in_stall);
        pending_pos.push_back(follow_step(nw, gg));
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        idle_burst();
    endtask

    task automatic drain();
        while (pending_pos.size() != 0) @(posedge i_clk);
        repeat (450) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_DAMPING) damp_q = val[15:0];
        else if (idx == CFG_MAX_SPEED) vmax_q = val;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom();
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    // Field extremes, zero distance, snap, the reset settings, edge settings and unused indexes
    task automatic test_directed();
        send_pos(0, 0, 0, 0, 0, 0);
        send_pos(0, 0, 0, 32'sh10000, 0, 0);
        send_pos(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_pos(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_pos(100, 200, 300, 100, 200, 300);
        send_pos(0, 0, 0, 1, -1, 1);
        send_pos(32'hFFFF_FFFF, 0, 32'h5555_5555, 32'hAAAA_AAAA, 0, 0);
        drain();
        write_reg(CFG_DAMPING, 31'd0);
        write_reg(CFG_MAX_SPEED, 31'h7FFF_FFFF);
        send_pos(0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_pos(32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 5, 5);
        send_pos(0, 0, 0, 10, 10, 10);
        drain();
        write_reg(CFG_DAMPING, 31'h0000_FFFF);
        write_reg(CFG_MAX_SPEED, 31'd0);
        write_reg(~CFG_MAX_SPEED, 31'h1234);
        write_reg(~CFG_DAMPING, 31'h7FFF_FFFF);
        send_pos(0, 0, 0, 32'sh7FFF_FFFF, 1, 1);
        send_pos(5, 5, 5, 32'sh8000_0000, 0, 0);
        drain();
    endtask

    // Follow wandering goals under random settings
    task automatic test_random(input int n_items);
        logic signed [31:0] px, py, pz, gx, gy, gz;
        for (int k = 0; k < n_items; k++) begin
            if (k % 150 == 0) begin
                drain();
                write_reg(CFG_DAMPING, $urandom_range(0, 3) == 0 ?
                          31'($urandom()) : 31'($urandom_range(1, 600)));
                write_reg(CFG_MAX_SPEED, $urandom_range(0, 3) == 0 ?
                          31'($urandom()) : 31'($urandom_range(0, 3000000)));
                px = rand_q(); py = rand_q(); pz = rand_q();
                gx = rand_q(); gy = rand_q(); gz = rand_q();
            end
            if ($urandom_range(0, 9) == 0) begin
                send_pos(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
            end else begin
                if ($urandom_range(0, 7) == 0) begin
                    gx = rand_q(); gy = rand_q(); gz = rand_q();
                end
                send_pos(px, py, pz, gx, gy, gz);
                px = pending_pos[$].nx; py = pending_pos[$].ny; pz = pending_pos[$].nz;
            end
        end
        drain();
    endtask

    // Hold the output off so the block stalls its input
    task automatic test_backpressure();
        fork
            begin
                hold_rx = 1'b1;
                repeat (1500) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            repeat (6) send_pos(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
        join
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        damp_q = RESET_DAMPING;
        vmax_q = RESET_MAX_SPEED;
        for (int i = 0; i < 3; i++) vel_q[i] = 0;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(1700);
        calm = 1'b1;
        test_random(230);
        if (mismatches == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    // Drive receiver stall in random bursts, held high in hold-off and low when calm
    always @(posedge i_clk) begin
        if (hold_rx) begin
            i_out_stall <= 1'b1;
        end else if (calm) begin
            i_out_stall <= 1'b0;
        end else if (i_out_stall) begin
            i_out_stall <= ($urandom_range(0, 2) != 0);
        end else begin
            i_out_stall <= ($urandom_range(0, 7) == 0);
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge i_clk) begin
        t_follow got, exp_pos;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_next_x, o_next_y, o_next_z, o_snapped};
            if (pending_pos.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                exp_pos = pending_pos.pop_front();
                if (got !== exp_pos) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %p got %p", exp_pos, got);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule
